/* rtl/sltab_pkg.sv */
// Shared types and constants for the sorted line table.
// Holds the entry layout, result status codes and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package sltab_pkg;

    localparam int KEY_W       = 16;
    localparam int HDL_W       = 16;
    localparam int IN_TDATA_W  = 32;   // line_number, text_handle
    localparam int OUT_TDATA_W = 40;   // 37 bits of fields, padded to 5 bytes
    localparam int OUT_FIELD_W = 37;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_INSERTED = 3'd1,
        ST_REPLACED = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [HDL_W-1:0] handle;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic    load_in;     // latch the input item
        logic    scan_start;  // read the last entry, pos := count
        logic    scan_take;   // keep entry under the pointer as candidate
        logic    ptr_dec;     // read one entry lower
        logic    ptr_inc;     // read one entry higher
        logic    shup_start;  // read the last entry for an upward shift
        logic    shup_move;   // entry under pointer goes one place up
        logic    shdn_start;  // read the entry above the candidate
        logic    shdn_move;   // entry under pointer goes one place down
        logic    put_new;     // write the latched key and handle at pos
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_res;     // record result status
        t_status res_status;
        logic    out_load;    // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic full;
        logic less;      // key read this cycle is below the offered key
        logic ptr_zero;
        logic ptr_top;   // pointer at the last held entry
        logic at_pos;    // pointer at the candidate position
        logic append;    // candidate position equals the count
        logic found;     // candidate holds the offered key
        logic empty;     // offered text is empty
        logic pos_top;   // candidate is the last held entry
    } t_dp_sts;

endpackage

/* rtl/sltab_dp.sv */
// Datapath of the sorted line table: entry memory, pointers, count and result register.
// Depends on sltab_pkg; driven by sltab_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module sltab_dp
    import sltab_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [KEY_W-1:0]       i_line_number,
    input  logic [HDL_W-1:0]       i_text_handle,
    input  logic                   i_text_empty,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    localparam int AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_entry                 r_mem [MAX_ENTRIES];
    t_entry                 r_rd;
    t_entry                 r_prev;
    logic [KEY_W-1:0]       r_key;
    logic [HDL_W-1:0]       r_hdl;
    logic                   r_empty;
    logic [AW-1:0]          r_ptr;
    logic [CW-1:0]          r_pos;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          n_cnt;
    t_status                r_res_status;
    logic                   r_rel_valid;
    logic [HDL_W-1:0]       r_rel_hdl;
    logic [OUT_TDATA_W-1:0] r_tdata;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] pos_p1;
    logic [CW-1:0] ptr_cw;
    logic [31:0]   pos_w;
    logic [31:0]   cnt_w;

    assign cnt_m1 = r_cnt - CW'(1);
    assign pos_p1 = r_pos + CW'(1);
    assign ptr_cw = CW'(r_ptr);
    assign pos_w  = 32'(r_pos);
    assign cnt_w  = 32'(r_cnt);

    // read address; the pointer always follows it
    always_comb begin
        rd_addr = r_ptr;
        if (i_cmd.scan_start || i_cmd.shup_start) begin
            rd_addr = cnt_m1[AW-1:0];
        end else if (i_cmd.shdn_start) begin
            rd_addr = pos_p1[AW-1:0];
        end else if (i_cmd.ptr_dec) begin
            rd_addr = r_ptr - AW'(1);
        end else if (i_cmd.ptr_inc) begin
            rd_addr = r_ptr + AW'(1);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = '{key: r_key, handle: r_hdl};
        if (i_cmd.shup_move) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr + AW'(1);
            wr_data = r_rd;
        end else if (i_cmd.shdn_move) begin
            wr_en   = 1'b1;
            wr_addr = r_ptr - AW'(1);
            wr_data = r_rd;
        end else if (i_cmd.put_new) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_cnt = cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= rd_addr;
        if (i_cmd.load_in) begin
            r_key   <= i_line_number;
            r_hdl   <= i_text_handle;
            r_empty <= i_text_empty;
        end
        if (i_cmd.scan_start) begin
            r_pos <= r_cnt;
        end else if (i_cmd.scan_take) begin
            r_pos  <= ptr_cw;
            r_prev <= r_rd;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_rel_valid  <= (i_cmd.res_status == ST_REPLACED) ||
                            (i_cmd.res_status == ST_REMOVED);
            r_rel_hdl    <= ((i_cmd.res_status == ST_REPLACED) ||
                             (i_cmd.res_status == ST_REMOVED)) ? r_prev.handle : '0;
        end
        if (i_cmd.out_load) begin
            r_tdata <= {(OUT_TDATA_W - OUT_FIELD_W)'(0), r_rel_valid, r_rel_hdl,
                        cnt_w[8:0], pos_w[7:0], r_res_status};
        end
    end

    assign o_tdata = r_tdata;

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.full     = (r_cnt == CW'(MAX_ENTRIES));
    assign o_sts.less     = (r_rd.key < r_key);
    assign o_sts.ptr_zero = (r_ptr == '0);
    assign o_sts.ptr_top  = (ptr_cw == cnt_m1);
    assign o_sts.at_pos   = (ptr_cw == r_pos);
    assign o_sts.append   = (r_pos == r_cnt);
    assign o_sts.found    = (r_pos != r_cnt) && (r_prev.key == r_key);
    assign o_sts.empty    = r_empty;
    assign o_sts.pos_top  = (r_pos == cnt_m1);

endmodule

/* rtl/sltab_ctrl.sv */
// Controller of the sorted line table: sequences scan, shift and write steps.
// Depends on sltab_pkg; drives sltab_dp through t_dp_cmd.
`timescale 1ns / 1ps

module sltab_ctrl
    import sltab_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHUP,
        S_INSWR,
        S_SHDN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = ST_APPENDED;
        n_state          = r_state;
        n_out_valid      = r_out_valid && !i_m_tready;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = i_sts.cnt_zero ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.less) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.scan_take = 1'b1;
                    if (i_sts.ptr_zero) begin
                        n_state = S_DECIDE;
                    end else begin
                        o_cmd.ptr_dec = 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.set_res = 1'b1;
                if (!i_sts.found) begin
                    if (i_sts.full) begin
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_FIN;
                    end else if (i_sts.append) begin
                        o_cmd.res_status = ST_APPENDED;
                        o_cmd.put_new    = 1'b1;
                        o_cmd.cnt_inc    = 1'b1;
                        n_state          = S_FIN;
                    end else begin
                        o_cmd.res_status = ST_INSERTED;
                        o_cmd.shup_start = 1'b1;
                        n_state          = S_SHUP;
                    end
                end else if (i_sts.empty) begin
                    o_cmd.res_status = ST_REMOVED;
                    if (i_sts.pos_top) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = S_FIN;
                    end else begin
                        o_cmd.shdn_start = 1'b1;
                        n_state          = S_SHDN;
                    end
                end else begin
                    o_cmd.res_status = ST_REPLACED;
                    o_cmd.put_new    = 1'b1;
                    n_state          = S_FIN;
                end
            end
            S_SHUP: begin
                o_cmd.shup_move = 1'b1;
                if (i_sts.at_pos) begin
                    n_state = S_INSWR;
                end else begin
                    o_cmd.ptr_dec = 1'b1;
                end
            end
            S_INSWR: begin
                o_cmd.put_new = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_FIN;
            end
            S_SHDN: begin
                o_cmd.shdn_move = 1'b1;
                if (i_sts.ptr_top) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/sorted_line_table_core.sv */
// Sorted line table: entries kept in ascending line-number order, one result per item.
// Each item: scan down from the top of the N held entries, then shift every later entry.
// A new item is taken only once the last one's result is in the result register; that register
// frees the input, but a result still waiting there holds the next item in its final state.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
// Depends on sltab_pkg, sltab_ctrl and sltab_dp.
`timescale 1ns / 1ps

module sorted_line_table_core
    import sltab_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] line_number, [31:16] text_handle
    input  logic                   i_s_axis_tuser,   // [0] text_empty
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // [2:0] status, [10:3] position,
                                                     // [19:11] entry_count,
                                                     // [35:20] released_handle,
                                                     // [36] released_valid, [39:37] zero
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: one state per step kind. The scan walks down from the last entry
    // (so a larger key is seen as an append at once), then an insert shifts later
    // entries up and a remove shifts them down, one entry per cycle.
    sltab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: single-port-read, single-port-write entry memory with registered
    // read data, scan pointer, candidate position and count, plus the result register.
    sltab_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_number (i_s_axis_tdata[KEY_W-1:0]),
        .i_text_handle (i_s_axis_tdata[KEY_W+HDL_W-1:KEY_W]),
        .i_text_empty  (i_s_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_tdata       (o_m_axis_tdata)
    );

endmodule
